// File: rtl/core/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ATTRIBUTE = 2'd2;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET = 6'd25;
	localparam logic [7:0] ATTRIBUTE_RESET = 8'h0F;

	localparam logic [7:0] CHR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_LINEFEED = 8'h0A;
	localparam logic [7:0] CHR_RETURN = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	typedef struct packed {
		logic action;
		logic [7:0] character;
		logic [11:0] read_address;
	} item_t;

	typedef struct packed {
		logic [11:0] cursor_location;
		logic [6:0] cursor_column;
		logic [4:0] cursor_row;
		logic scrolled;
		logic [15:0] cell_data;
	} result_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_READ,
		CMD_BACKSPACE,
		CMD_TAB,
		CMD_RETURN,
		CMD_LINEFEED,
		CMD_PRINT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] character;
		logic [11:0] read_address;
		logic addr_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} back_state_t;

endpackage

// File: rtl/core/tcce_fifo.sv
`timescale 1ns / 1ps

module tcce_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [W-1:0] rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CNW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CNW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/tcce_front.sv
`timescale 1ns / 1ps

module tcce_front #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tcce_pkg::item_t item,
	input logic busy,
	input logic cmd_full,
	output logic cmd_push,
	output tcce_pkg::cmd_t cmd
);

	import tcce_pkg::*;

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;

	cmd_t cls;
	cmd_t cmd_s1;
	logic valid_s1;
	logic accept;

	always_comb begin
		cls.character = item.character;
		cls.read_address = item.read_address;
		cls.addr_ok = (32'(item.read_address) < 32'(CELL_COUNT));
		if (item.action) begin
			cls.kind = CMD_READ;
		end else begin
			case (item.character)
				CHR_BACKSPACE: cls.kind = CMD_BACKSPACE;
				CHR_TAB: cls.kind = CMD_TAB;
				CHR_RETURN: cls.kind = CMD_RETURN;
				CHR_LINEFEED: cls.kind = CMD_LINEFEED;
				default: cls.kind = (item.character >= CHR_SPACE) ? CMD_PRINT : CMD_NOP;
			endcase
		end
	end

	assign full = busy || (valid_s1 && cmd_full);
	assign accept = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// File: rtl/core/tcce_back.sv
`timescale 1ns / 1ps

module tcce_back #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 32,
	parameter int TAB_STOP = 8
) (
	input logic clk,
	input logic arst_n,
	input logic write_enable,
	input logic [tcce_pkg::CFG_INDEX_W-1:0] write_index,
	input logic [tcce_pkg::CFG_DATA_W-1:0] write_data,
	input logic cmd_empty,
	output logic cmd_pop,
	input tcce_pkg::cmd_t cmd,
	input logic res_full,
	output logic res_push,
	output tcce_pkg::result_t res,
	output logic busy
);

	import tcce_pkg::*;

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = $clog2(CELL_COUNT + 1);
	localparam int WW = $clog2(MAX_COLUMNS + 1);
	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int CLW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int XW = $clog2(MAX_COLUMNS + TAB_STOP);
	localparam int PW = $clog2(TAB_STOP);

	logic [7:0] columns_q;
	logic [5:0] rows_q;
	logic [7:0] attr_q;
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [CW-1:0] last_q;
	logic [CW-1:0] total_q;

	back_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [CLW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [PW-1:0] phase_q, phase_d;
	logic scrolled_q, scrolled_d;
	logic [CW-1:0] rcnt_q, rcnt_d;
	logic [CW-1:0] wcnt_q, wcnt_d;
	logic pend_q, pend_d;

	logic [15:0] mem [CELL_COUNT];
	logic [15:0] rdata_q;
	logic we;
	logic [AW-1:0] wa;
	logic [15:0] wd;
	logic re;
	logic [AW-1:0] ra;

	logic [CW-1:0] cur_index;
	logic [XW-1:0] ncol;
	logic [HW-1:0] nrow;
	logic [PW-1:0] nphase;
	logic do_print;
	logic scroll;

	always_comb begin
		if (columns_q == '0) begin
			w = WW'(1);
		end else if (32'(columns_q) > 32'(MAX_COLUMNS)) begin
			w = WW'(MAX_COLUMNS);
		end else begin
			w = WW'(columns_q);
		end
		if (rows_q == '0) begin
			h = HW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			h = HW'(MAX_ROWS);
		end else begin
			h = HW'(rows_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
			attr_q <= ATTRIBUTE_RESET;
		end else if (write_enable) begin
			case (write_index)
				CFG_COLUMNS: columns_q <= write_data;
				CFG_ROWS: rows_q <= write_data[5:0];
				CFG_ATTRIBUTE: attr_q <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		last_q <= CW'(h - HW'(1)) * CW'(w);
		total_q <= last_q + CW'(w);
	end

	assign cur_index = CW'(row_q) * CW'(w) + CW'(col_q);

	always_comb begin
		ncol = XW'(col_q);
		nrow = HW'(row_q);
		nphase = phase_q;
		do_print = 1'b0;
		case (cmd_q.kind)
			CMD_BACKSPACE: begin
				if (col_q != '0) begin
					ncol = XW'(col_q) - XW'(1);
					nphase = (phase_q == '0) ? PW'(TAB_STOP - 1) : phase_q - PW'(1);
				end
			end
			CMD_TAB: begin
				ncol = XW'(col_q) + XW'(TAB_STOP) - XW'(phase_q);
				nphase = '0;
			end
			CMD_RETURN: begin
				ncol = '0;
				nphase = '0;
			end
			CMD_LINEFEED: begin
				ncol = '0;
				nphase = '0;
				nrow = HW'(row_q) + HW'(1);
			end
			CMD_PRINT: begin
				do_print = 1'b1;
				ncol = XW'(col_q) + XW'(1);
				nphase = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
			end
			default: ;
		endcase
		if (ncol >= XW'(w)) begin
			ncol = '0;
			nphase = '0;
			nrow = nrow + HW'(1);
		end
		scroll = (nrow >= h);
		if (scroll) begin
			nrow = h - HW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		row_d = row_q;
		phase_d = phase_q;
		scrolled_d = scrolled_q;
		rcnt_d = rcnt_q;
		wcnt_d = wcnt_q;
		pend_d = 1'b0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = wcnt_q[AW-1:0];
				if (wcnt_q == CW'(CELL_COUNT - 1)) begin
					wcnt_d = '0;
					state_d = ST_IDLE;
				end else begin
					wcnt_d = wcnt_q + CW'(1);
				end
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q.kind == CMD_READ) begin
					re = cmd_q.addr_ok;
					ra = AW'(cmd_q.read_address);
					scrolled_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					we = do_print;
					wa = cur_index[AW-1:0];
					wd = {attr_q, cmd_q.character};
					col_d = CLW'(ncol);
					row_d = RW'(nrow);
					phase_d = nphase;
					scrolled_d = scroll;
					rcnt_d = CW'(w);
					wcnt_d = '0;
					state_d = scroll ? ST_COPY : ST_DONE;
				end
			end
			ST_COPY: begin
				re = (rcnt_q < total_q);
				ra = rcnt_q[AW-1:0];
				pend_d = re;
				if (re) begin
					rcnt_d = rcnt_q + CW'(1);
				end
				if (pend_q) begin
					we = 1'b1;
					wa = wcnt_q[AW-1:0];
					wd = rdata_q;
					wcnt_d = wcnt_q + CW'(1);
				end
				if (!re && !pend_q) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				we = 1'b1;
				wa = wcnt_q[AW-1:0];
				wd = {attr_q, CHR_SPACE};
				wcnt_d = wcnt_q + CW'(1);
				if (wcnt_q == total_q - CW'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q <= '0;
			row_q <= '0;
			phase_q <= '0;
			scrolled_q <= 1'b0;
			rcnt_q <= '0;
			wcnt_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			phase_q <= phase_d;
			scrolled_q <= scrolled_d;
			rcnt_q <= rcnt_d;
			wcnt_q <= wcnt_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	always_comb begin
		res.cursor_location = 12'(cur_index);
		res.cursor_column = 7'(col_q);
		res.cursor_row = 5'(row_q);
		res.scrolled = scrolled_q;
		res.cell_data = (cmd_q.kind == CMD_READ && cmd_q.addr_ok) ? rdata_q : 16'h0000;
	end

	assign busy = (state_q == ST_CLEAR);

endmodule

// File: rtl/core/text_console_character_engine_core.sv
`timescale 1ns / 1ps

// A result passes through the front register, the command FIFO, the IDLE, EXEC
// and DONE states of the sequencer and the result FIFO; later items wait queued.
// A put that scrolls also copies the screen up a row and blank-fills the last row.
// Reset: cursor and registers return to defaults, then the screen store is cleared
// (all MAX_COLUMNS*MAX_ROWS cells, 4096 by default) while full stays high.
module text_console_character_engine_core #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS = 32,
	parameter int TAB_STOP = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tcce_pkg::item_t item,
	output logic empty,
	input logic pop,
	output tcce_pkg::result_t result,
	input logic write_enable,
	input logic [tcce_pkg::CFG_INDEX_W-1:0] write_index,
	input logic [tcce_pkg::CFG_DATA_W-1:0] write_data
);

	import tcce_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	result_t res;
	logic res_push;
	logic res_full;
	logic busy;

	tcce_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.busy(busy),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	tcce_fifo #(
		.W($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(cmd_out),
		.empty(cmd_empty)
	);

	tcce_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.TAB_STOP(TAB_STOP)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.cmd(cmd_out),
		.res_full(res_full),
		.res_push(res_push),
		.res(res),
		.busy(busy)
	);

	tcce_fifo #(
		.W($bits(result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(result),
		.empty(empty)
	);

endmodule

// File: bench/console_scoreboard_pkg.sv
`timescale 1ns / 1ps

package console_scoreboard_pkg;

	import tcce_pkg::*;

	localparam logic ACTION_PUT = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_ROWS = 32;
	localparam int TAB_WIDTH = 8;
	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

	class console_scoreboard;
		logic [15:0] cells [CELL_COUNT];
		int cur_col;
		int cur_row;
		logic [7:0] columns;
		logic [5:0] rows;
		logic [7:0] attribute;
		result_t expected_q[$];
		int errors;

		function new();
			foreach (cells[i]) cells[i] = 16'h0000;
			cur_col = 0;
			cur_row = 0;
			columns = COLUMNS_RESET;
			rows = ROWS_RESET;
			attribute = ATTRIBUTE_RESET;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] index,
			logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_COLUMNS: begin
					columns = value;
				end
				CFG_ROWS: begin
					rows = value[5:0];
				end
				CFG_ATTRIBUTE: begin
					attribute = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Out-of-range sizes saturate; zero behaves as one.
		function int width_in_use();
			if (columns == 0)
				return 1;
			if (columns > SCREEN_COLUMNS)
				return SCREEN_COLUMNS;
			return int'(columns);
		endfunction

		function int height_in_use();
			if (rows == 0)
				return 1;
			if (rows > SCREEN_ROWS)
				return SCREEN_ROWS;
			return int'(rows);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(item_t it);
			int w;
			int h;
			int cell_index;
			int loc;
			int i;
			logic did_scroll;
			logic [15:0] cell_value;
			result_t want;

			w = width_in_use();
			h = height_in_use();
			did_scroll = 1'b0;
			cell_value = 16'h0000;
			if (it.action == ACTION_READ) begin
				cell_value = cells[it.read_address];
			end else begin
				case (it.character)
					CHR_BACKSPACE: begin
						if (cur_col != 0)
							cur_col--;
					end
					CHR_TAB: begin
						cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
					end
					CHR_RETURN: begin
						cur_col = 0;
					end
					CHR_LINEFEED: begin
						cur_col = 0;
						cur_row++;
					end
					default: begin
						if (it.character >= CHR_SPACE) begin
							cell_index = cur_row * w + cur_col;
							if (cell_index < CELL_COUNT)
								cells[cell_index] = {attribute, it.character};
							cur_col++;
						end
					end
				endcase
				if (cur_col >= w) begin
					cur_col = 0;
					cur_row++;
				end
				// A single scroll, however far below the screen the row landed.
				if (cur_row >= h) begin
					for (i = 0; i < (h - 1) * w; i++)
						cells[i] = cells[i + w];
					for (i = (h - 1) * w; i < h * w; i++)
						cells[i] = {attribute, CHR_SPACE};
					cur_row = h - 1;
					did_scroll = 1'b1;
				end
			end
			loc = cur_row * w + cur_col;
			want.cursor_location = loc[11:0];
			want.cursor_column = cur_col[6:0];
			want.cursor_row = cur_row[4:0];
			want.scrolled = did_scroll;
			want.cell_data = cell_value;
			expected_q.push_back(want);
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;

			if (expected_q.size() == 0) begin
				$error("result arrived with no item waiting");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("cursor_location", 16'(want.cursor_location),
				16'(got.cursor_location));
			compare_field("cursor_column", 16'(want.cursor_column),
				16'(got.cursor_column));
			compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
			compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
			compare_field("cell_data", want.cell_data, got.cell_data);
		endfunction
	endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import tcce_pkg::*;
	import console_scoreboard_pkg::*;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	item_t item;
	logic empty;
	logic pop;
	result_t result;
	logic write_enable;
	logic [CFG_INDEX_W-1:0] write_index;
	logic [CFG_DATA_W-1:0] write_data;

	console_scoreboard sb;
	int push_gap_max;
	int pop_gap_max;

	text_console_character_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data)
	);

	always #10 clk = ~clk;

	function automatic item_t put_of(logic [7:0] ch);
		item_t it;

		it.action = ACTION_PUT;
		it.character = ch;
		it.read_address = 12'($urandom_range(0, 4095));
		return it;
	endfunction

	function automatic item_t read_of(logic [11:0] address);
		item_t it;

		it.action = ACTION_READ;
		it.character = 8'($urandom_range(0, 255));
		it.read_address = address;
		return it;
	endfunction

	function automatic item_t random_item(int lf_pct);
		item_t it;
		int pick;

		it = put_of(8'($urandom_range(CHR_SPACE, 255)));
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it.action = ACTION_READ;
			if ($urandom_range(0, 1) == 1)
				it.read_address = 12'($urandom_range(0,
					sb.width_in_use() * sb.height_in_use() - 1));
		end else if (pick < 15 + lf_pct) begin
			it.character = CHR_LINEFEED;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				it.character = CHR_BACKSPACE;
			else if (pick < 20)
				it.character = CHR_TAB;
			else if (pick < 28)
				it.character = CHR_RETURN;
			else if (pick < 36)
				it.character = 8'($urandom_range(0, CHR_SPACE - 1));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;

		gap = $urandom_range(0, push_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.note_item(it);
	endtask

	// Drain all outstanding results, then give the block time to go idle.
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_screen(input logic [7:0] cols, input logic [5:0] height,
		input logic [7:0] attr);
		write_enable <= 1'b1;
		write_index <= CFG_COLUMNS;
		write_data <= cols;
		@(posedge clk);
		write_index <= CFG_ROWS;
		write_data <= {2'b00, height};
		@(posedge clk);
		write_index <= CFG_ATTRIBUTE;
		write_data <= attr;
		@(posedge clk);
		write_enable <= 1'b0;
		sb.set_register(CFG_COLUMNS, cols);
		sb.set_register(CFG_ROWS, {2'b00, height});
		sb.set_register(CFG_ATTRIBUTE, attr);
	endtask

	task automatic run_phase(input logic [7:0] cols, input logic [5:0] height,
		input logic [7:0] attr, input int count, input int in_gap, input int out_gap,
		input int lf_pct);
		program_screen(cols, height, attr);
		push_gap_max = in_gap;
		pop_gap_max = out_gap;
		repeat (count) send_item(random_item(lf_pct));
		settle();
	endtask

	initial begin : result_drain
		int gap;

		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, pop_gap_max);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(result);
		end
	end

	initial begin : stimulus
		int k;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		write_enable = 1'b0;
		write_index = '0;
		write_data = '0;
		push_gap_max = 13;
		pop_gap_max = 13;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults straight out of reset.
		send_item(put_of(8'h48));
		send_item(put_of(CHR_TAB));
		send_item(read_of(12'd0));
		send_item(put_of(CHR_LINEFEED));
		send_item(read_of(12'd80));
		send_item(put_of(8'h00));
		settle();

		// A tiny screen makes wrap and scroll easy to reach by hand.
		program_screen(8'd10, 6'd3, 8'hA5);
		send_item(put_of(CHR_RETURN));
		send_item(put_of(CHR_SPACE));
		send_item(put_of(8'h41));
		send_item(put_of(8'h7F));
		send_item(put_of(8'h80));
		send_item(put_of(8'hFF));
		send_item(put_of(CHR_BACKSPACE));
		send_item(put_of(CHR_RETURN));
		send_item(put_of(CHR_BACKSPACE));
		send_item(put_of(CHR_TAB));
		send_item(put_of(8'h7A));
		send_item(put_of(CHR_TAB));
		send_item(put_of(CHR_TAB));
		send_item(put_of(CHR_LINEFEED));
		send_item(put_of(8'h1F));
		send_item(put_of(8'h00));
		send_item(put_of(8'h1B));
		send_item(read_of(12'd0));
		send_item(read_of(12'd10));
		send_item(read_of(12'd29));
		send_item(read_of(12'd4095));
		send_item(read_of(12'hAAA));
		send_item(put_of(8'h7E));
		settle();

		run_phase(8'd16, 6'd4, 8'($urandom_range(0, 255)), 120, 13, 13, 8);
		run_phase(8'd0, 6'd0, 8'h00, 40, 0, 0, 6);
		run_phase(8'd128, 6'd2, 8'($urandom_range(0, 255)), 80, 13, 0, 10);
		run_phase(8'd1, 6'd32, 8'($urandom_range(0, 255)), 60, 0, 13, 6);
		run_phase(8'd255, 6'd63, 8'hFF, 40, 13, 13, 50);
		run_phase(8'd128, 6'd32, 8'h80, 20, 0, 13, 50);
		for (k = 0; k < 8; k++)
			run_phase(8'($urandom_range(1, 24)), 6'($urandom_range(1, 10)),
				8'($urandom_range(0, 255)),
				48, ($urandom_range(0, 1) == 1) ? 13 : 0,
				($urandom_range(0, 1) == 1) ? 13 : 0, $urandom_range(6, 20));

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/tcce_pkg.sv
rtl/core/tcce_fifo.sv
rtl/core/tcce_front.sv
rtl/core/tcce_back.sv
rtl/core/text_console_character_engine_core.sv
bench/console_scoreboard_pkg.sv
bench/tb_top.sv
